// ----- sv/sftl_pkg.sv -----
// Package for the sorted fixup table lookup block.
// Holds op and status codes, stream widths and the controller/datapath structs.
// No dependencies; used by sftl_ctrl, sftl_dp and sorted_fixup_table_lookup.
`timescale 1ns / 1ps

package sftl_pkg;

    // Default table size
    localparam int TABLE_DEPTH_DEF = 256;

    // Field widths
    localparam int ADDR_W        = 64;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 9;

    // Stream widths: tdata padded to whole bytes
    localparam int S_DATA_W = 3 * ADDR_W;
    localparam int M_DATA_W = ((ADDR_W + ENTRY_COUNT_W + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - ADDR_W - ENTRY_COUNT_W;

    // Op codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic                load;
        logic                srch_init;
        logic                rd_mid;
        logic                srch_upd;
        logic                shift_init;
        logic                shift_rd;
        logic                shift_wr;
        logic                ins_wr;
        logic                clear;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                res_found;
    } sftl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            srch_done;
        logic            key_eq;
        logic            key_lt;
        logic            shift_done;
    } sftl_sts_t;

endpackage

// ----- sv/sftl_ctrl.sv -----
// Controller state machine for the sorted fixup table lookup block.
// Sequences search, shift, insert, clear and result load; depends on sftl_pkg.
`timescale 1ns / 1ps

module sftl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              m_tready,
    output logic              m_tvalid,
    input  sftl_pkg::sftl_sts_t sts,
    output sftl_pkg::sftl_cmd_t cmd
);
    import sftl_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISPATCH  = 3'd1;
    localparam logic [2:0] S_SRCH_RD   = 3'd2;
    localparam logic [2:0] S_SRCH_CMP  = 3'd3;
    localparam logic [2:0] S_SHIFT_CHK = 3'd4;
    localparam logic [2:0] S_SHIFT_WR  = 3'd5;
    localparam logic [2:0] S_FINISH    = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic                found_reg, found_next;
    logic                m_valid_reg, m_valid_next;
    logic                out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        found_next = found_reg;
        cmd        = '0;
        cmd.res_status = st_reg;
        cmd.res_found  = found_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                found_next = 1'b0;
                st_next    = ST_OK;
                priority if (sts.op == OP_INSERT && sts.full) begin
                    st_next    = ST_FULL;
                    state_next = S_FINISH;
                end else if (sts.op == OP_INSERT || sts.op == OP_LOOKUP) begin
                    cmd.srch_init = 1'b1;
                    state_next    = S_SRCH_RD;
                end else if (sts.op == OP_CLEAR) begin
                    cmd.clear  = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SRCH_RD: begin
                priority if (!sts.srch_done) begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_SRCH_CMP;
                end else if (sts.op == OP_LOOKUP) begin
                    st_next    = ST_MISS;
                    state_next = S_FINISH;
                end else begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT_CHK;
                end
            end
            S_SRCH_CMP: begin
                if (sts.op == OP_LOOKUP && sts.key_eq) begin
                    found_next = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    cmd.srch_upd = 1'b1;
                    state_next   = S_SRCH_RD;
                end
            end
            S_SHIFT_CHK: begin
                if (sts.shift_done) begin
                    cmd.ins_wr = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_CHK;
            end
            S_FINISH: begin
                // Hold until the output register is free
                if (out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on result load, drop once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            st_reg      <= ST_OK;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            st_reg      <= st_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- sv/sftl_dp.sv -----
// Datapath for the sorted fixup table lookup block.
// Key and fixup memories, search bounds, shift index and result register; uses sftl_pkg.
`timescale 1ns / 1ps

module sftl_dp #(
    parameter int TABLE_DEPTH = sftl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [sftl_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic [sftl_pkg::OP_W-1:0]           s_tuser,
    output logic [sftl_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [sftl_pkg::STATUS_W-1:0]       m_tuser,
    input  sftl_pkg::sftl_cmd_t                 cmd,
    output sftl_pkg::sftl_sts_t                 sts
);
    import sftl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Table memories
    logic [ADDR_W-1:0] key_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0] fix_mem [TABLE_DEPTH];

    logic [OP_W-1:0]     op_reg;
    logic [ADDR_W-1:0]   key_reg;
    logic [ADDR_W-1:0]   fix_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    mid_reg;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [ADDR_W-1:0]   rd_key_reg;
    logic [ADDR_W-1:0]   rd_fix_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ADDR_W-1:0]   res_fix_reg;
    logic [ENTRY_COUNT_W-1:0] res_count_reg;

    logic [CNT_W-1:0]    mid;
    logic                go_right;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]   wr_key;
    logic [ADDR_W-1:0]   wr_fix;
    logic [CNT_W+ENTRY_COUNT_W-1:0] count_ext;

    // Midpoint and compare
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_right = sts.key_lt || (op_reg == OP_INSERT && sts.key_eq);

    assign sts.op         = op_reg;
    assign sts.full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign sts.srch_done  = (lo_reg >= hi_reg);
    assign sts.key_eq     = (rd_key_reg == key_reg);
    assign sts.key_lt     = (rd_key_reg < key_reg);
    assign sts.shift_done = (k_reg == lo_reg);

    // Memory port selection
    assign rd_en   = cmd.rd_mid || cmd.shift_rd;
    assign rd_addr = cmd.shift_rd ? IDX_W'(k_reg - CNT_W'(1)) : mid[IDX_W-1:0];
    assign wr_en   = cmd.shift_wr || cmd.ins_wr;
    assign wr_addr = cmd.shift_wr ? k_reg[IDX_W-1:0] : lo_reg[IDX_W-1:0];
    assign wr_key  = cmd.shift_wr ? rd_key_reg : key_reg;
    assign wr_fix  = cmd.shift_wr ? rd_fix_reg : fix_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            fix_mem[wr_addr] <= wr_fix;
        end
        if (rd_en) begin
            rd_key_reg <= key_mem[rd_addr];
            rd_fix_reg <= fix_mem[rd_addr];
        end
    end

    // Search bounds, shift index and entry count
    always_comb begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        count_next = count_reg;
        if (cmd.srch_init) begin
            lo_next = '0;
            hi_next = count_reg;
        end
        if (cmd.srch_upd) begin
            if (go_right) begin
                lo_next = mid_reg + CNT_W'(1);
            end else begin
                hi_next = mid_reg;
            end
        end
        if (cmd.shift_init) begin
            k_next = count_reg;
        end
        if (cmd.shift_wr) begin
            k_next = k_reg - CNT_W'(1);
        end
        if (cmd.ins_wr) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.clear) begin
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Latch the accepted word and the working registers
    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        k_reg  <= k_next;
        if (cmd.rd_mid) begin
            mid_reg <= mid;
        end
        if (cmd.load) begin
            op_reg  <= s_tuser;
            key_reg <= (s_tuser == OP_LOOKUP) ? s_tdata[3*ADDR_W-1:2*ADDR_W]
                                               : s_tdata[ADDR_W-1:0];
            fix_reg <= s_tdata[2*ADDR_W-1:ADDR_W];
        end
    end

    // Output register
    assign count_ext = {{ENTRY_COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_fix_reg    <= cmd.res_found ? rd_fix_reg : '0;
            res_count_reg  <= count_ext[ENTRY_COUNT_W-1:0];
        end
    end

    assign m_tuser = res_status_reg;
    assign m_tdata = {{M_PAD_W{1'b0}}, res_count_reg, res_fix_reg};

endmodule

// ----- sv/sorted_fixup_table_lookup.sv -----
// Top level of the sorted fixup table lookup block.
// Joins sftl_ctrl and sftl_dp; depends on sftl_pkg.
//
// Usage: one word in on the s_ stream, one result word out on the m_ stream.
// s_tuser carries the op (insert, lookup, clear); s_tdata carries the insert
// key, the insert fixup address and the lookup address. m_tuser carries the
// status and m_tdata the fixup address on a hit and the entry count after the
// word. The table stays sorted by key, equal keys in arrival order.
// One word is worked on at a time. A lookup or insert runs a binary search of
// at most ceil(log2(count+1)) steps; each step is one read of the key memory
// and one compare. An insert then moves the entries above its slot up one
// slot, each by a read and then a write of the memories, and writes the new
// entry. Clear and full or unused ops go straight from dispatch to the result.
// A new word is accepted the cycle after the result is loaded into the output
// register, even while that result waits.
// If the receiver stalls, the result holds in the output register and the
// next word stalls before its result is loaded. Reset empties the table and
// drops any pending result; the memories themselves are not cleared.
`timescale 1ns / 1ps

module sorted_fixup_table_lookup #(
    parameter int TABLE_DEPTH = sftl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // insn_addr [63:0], fixup_addr_in [127:64], fault_addr [191:128]
    input  logic [sftl_pkg::S_DATA_W-1:0]   s_tdata,
    // op [1:0]
    input  logic [sftl_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // fixup_addr_out [63:0], entry_count [72:64], zero [79:73]
    output logic [sftl_pkg::M_DATA_W-1:0]   m_tdata,
    // status [1:0]
    output logic [sftl_pkg::STATUS_W-1:0]   m_tuser
);
    import sftl_pkg::*;

    sftl_cmd_t cmd;
    sftl_sts_t sts;

    sftl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    sftl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cmd     (cmd),
        .sts     (sts)
    );

`ifndef SYNTHESIS
    // One word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("word accepted while previous word in work");

    // Never overwrite a result that waits on the receiver
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while stalled");

    // Write the new entry only once the tail shift has reached its slot
    a_insert_at_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_wr |-> sts.shift_done && !sts.full)
        else $error("insert written before shift finished or into full table");
`endif

endmodule
